[src/effk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// effk_pkg
// Shared widths, Q32.32 saturation bounds and saturating add/subtract for the
// edge fluid friction kernel.
// ----------------------------------------------------------------------------
package effk_pkg;

	// field and datapath widths
	localparam int unsigned InW      = 32;
	localparam int unsigned QW       = 64;
	localparam int unsigned CfgAddrW = 3;
	localparam int unsigned NStage   = 15;

	// q32.32 value
	typedef logic signed [QW-1:0] q_t;

	// register index taken from the word address
	typedef logic [CfgAddrW-3:0] reg_idx_t;
	localparam reg_idx_t RegFrictionGain = '0;

	// saturation bounds
	localparam q_t QMax = {1'b0, {(QW-1){1'b1}}};
	localparam q_t QMin = {1'b1, {(QW-1){1'b0}}};

	// a + b clamped to the signed 64-bit range
	function automatic q_t sat_add(input q_t a, input q_t b);
		logic [QW:0] s;
		s = {a[QW-1], a} + {b[QW-1], b};
		if (s[QW] != s[QW-1]) begin
			sat_add = s[QW] ? QMin : QMax;
		end else begin
			sat_add = s[QW-1:0];
		end
	endfunction

	// a - b clamped to the signed 64-bit range
	function automatic q_t sat_sub(input q_t a, input q_t b);
		logic [QW:0] s;
		s = {a[QW-1], a} - {b[QW-1], b};
		if (s[QW] != s[QW-1]) begin
			sat_sub = s[QW] ? QMin : QMax;
		end else begin
			sat_sub = s[QW-1:0];
		end
	endfunction

endpackage

[src/effk_qmul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// effk_qmul
// Two-stage Q32.32 by Q32.32 multiplier: four 32x32 partial products in the
// first stage, sum with round-half-up and saturation in the second.
// ----------------------------------------------------------------------------
module effk_qmul import effk_pkg::*; (
	input  logic clk,
	input  logic en_a,
	input  logic en_b,
	input  q_t   a,
	input  q_t   b,
	output q_t   p
);

	// half an lsb of the Q32.32 result, 2^31 in the full product
	localparam logic [2*QW-1:0] RoundHalf = {{(2*QW-32){1'b0}}, 1'b1, 31'd0};

	logic signed [31:0]   a_hi, b_hi;
	logic signed [32:0]   a_lo, b_lo;
	logic [63:0]          pp_ll_s1;
	logic signed [64:0]   pp_hl_s1, pp_lh_s1;
	logic signed [63:0]   pp_hh_s1;
	logic signed [65:0]   mid;
	logic [2*QW-1:0]      sum;
	q_t                   res;
	q_t                   p_s2;

	// split operands into signed high and unsigned low halves
	assign a_hi = a[63:32];
	assign b_hi = b[63:32];
	assign a_lo = signed'({1'b0, a[31:0]});
	assign b_lo = signed'({1'b0, b[31:0]});

	// partial products
	always_ff @(posedge clk) begin
		if (en_a) begin
			pp_ll_s1 <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
			pp_hl_s1 <= 65'(a_hi) * 65'(b_lo);
			pp_lh_s1 <= 65'(a_lo) * 65'(b_hi);
			pp_hh_s1 <= 64'(a_hi) * 64'(b_hi);
		end
	end

	// full product plus half lsb, then clamp bits 95:32
	always_comb begin
		mid = 66'(pp_hl_s1) + 66'(pp_lh_s1);
		sum = {pp_hh_s1, 64'd0} + {{30{mid[65]}}, mid, 32'd0} + {64'd0, pp_ll_s1} + RoundHalf;
		if (&sum[127:95] || ~|sum[127:95]) begin
			res = sum[95:32];
		end else begin
			res = sum[127] ? QMin : QMax;
		end
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			p_s2 <= res;
		end
	end

	assign p = p_s2;

endmodule

[src/edge_fluid_friction_kernel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_fluid_friction_kernel
// Per-edge fluid friction energy, gradient and Hessian-times-direction terms
// in saturating Q32.32 arithmetic.
// ----------------------------------------------------------------------------
// The block takes one edge per clock while in_stall is low and returns the
// results in order, one result per edge. The pipeline depth comes from
// four chained levels of Q32.32 multiplies (squares, cubes and fourth powers,
// products with the edge vector and direction, and the final gain), each a
// two-stage 64x64 unit built from four 32x32 partial products, with a
// saturating add stage between levels. Every stage holds its own valid bit,
// so a stalled output only stops the stages behind it that are full, and
// bubbles are squeezed out. friction_gain lies at byte address 0 and is to be
// written only while no edge is in flight; it resets to zero.
// ----------------------------------------------------------------------------
module edge_fluid_friction_kernel import effk_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [CfgAddrW-1:0]  paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [InW-1:0] cur_x,
	input  logic signed [InW-1:0] cur_y,
	input  logic signed [InW-1:0] prev_x,
	input  logic signed [InW-1:0] prev_y,
	input  logic signed [InW-1:0] neighbor_prev_x,
	input  logic signed [InW-1:0] neighbor_prev_y,
	input  logic signed [InW-1:0] dir_x,
	input  logic signed [InW-1:0] dir_y,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [QW-1:0] energy_term,
	output logic signed [QW-1:0] grad_x,
	output logic signed [QW-1:0] grad_y,
	output logic signed [QW-1:0] diff_x,
	output logic signed [QW-1:0] diff_y,
	output logic                 active
);

	// values that ride along the pipe
	typedef struct packed {
		logic               pos;
		logic signed [32:0] px;
		logic signed [32:0] py;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
	} side_t;

	localparam logic [NStage-1:0] AllValid = '1;

	// clamp an exact 67-bit Q32.32 value
	function automatic q_t sat_t(input logic [66:0] w);
		if (&w[66:63] || ~|w[66:63]) begin
			sat_t = w[63:0];
		end else begin
			sat_t = w[66] ? QMin : QMax;
		end
	endfunction

	// Q16.16 edge component to Q32.32
	function automatic q_t widen_p(input logic [32:0] v);
		widen_p = {{15{v[32]}}, v, 16'd0};
	endfunction

	// Q16.16 input to Q32.32
	function automatic q_t widen_d(input logic [31:0] v);
		widen_d = {{16{v[31]}}, v, 16'd0};
	endfunction

	logic                 cfg_wr;
	reg_idx_t             reg_idx;
	logic [31:0]          friction_gain_q;
	logic [33:0]          gain3;
	q_t                   kf, kf4, kf3;

	logic [NStage-1:0]    vld_q;
	logic [NStage-1:0]    en;

	logic signed [32:0]   vx_s1, vy_s1, px_s1, py_s1;
	logic signed [31:0]   dx_s1, dy_s1;
	logic signed [65:0]   vypx_s2, vxpy_s2, vxpx_s2, vypy_s2;
	logic signed [32:0]   px_s2, py_s2;
	logic signed [31:0]   dx_s2, dy_s2;
	logic [66:0]          t1w, t2w;
	q_t                   t1_s3, t2_s3, t1_s4, t2_s4, t1_s5, t2_s5, t1_s6, t2_s6;
	side_t                side_s [3:NStage-1];
	q_t                   qpx3, qpy3, qpx9, qpy9, dx9, dy9;

	q_t s1_s5, s2_s5, pxx_s5, pyy_s5, pxy_s5;
	q_t s1_s6, s2_s6, pxx_s6, pyy_s6, pxy_s6, d21_s6;
	q_t c1_s8, c2_s8, e1_s8, e2_s8, h1_s8, h2_s8, h3_s8, h4_s8, hxy_s8;
	q_t esum_s9, hxx_s9, hyy_s9, c1_s9, c2_s9, hxy_s9;
	q_t g1_s11, g2_s11, g3_s11, g4_s11, d1_s11, d2_s11, d3_s11, d4_s11, energy_s11;
	q_t gx_s12, gy_s12, dfx_s12, dfy_s12, energy_s12, energy_s13, energy_s14;
	q_t grad_x_s14, grad_y_s14, diff_x_s14, diff_y_s14;
	q_t energy_s15, grad_x_s15, grad_y_s15, diff_x_s15, diff_y_s15;
	logic active_s15;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[CfgAddrW-1:2];
	assign prdata  = (reg_idx == RegFrictionGain) ? friction_gain_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			friction_gain_q <= '0;
		end else if (cfg_wr && reg_idx == RegFrictionGain) begin
			friction_gain_q <= pwdata;
		end
	end

	// gain constants kF, kF/4 and 3kF in Q32.32
	assign gain3 = {1'b0, friction_gain_q, 1'b0} + {2'b00, friction_gain_q};
	assign kf    = {16'd0, friction_gain_q, 16'd0};
	assign kf4   = {18'd0, friction_gain_q, 14'd0};
	assign kf3   = {14'd0, gain3, 16'd0};

	// stage enables: a stage loads when some stage at or after it is free
	always_comb begin
		for (int k = 0; k < NStage; k++) begin
			en[k] = !out_stall || ((vld_q >> k) != (AllValid >> k));
		end
	end

	assign in_stall  = !en[0];
	assign out_valid = vld_q[NStage-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NStage; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// stage 1: velocity and edge vector
	always_ff @(posedge clk) begin
		if (en[0]) begin
			vx_s1 <= 33'(cur_x) - 33'(prev_x);
			vy_s1 <= 33'(cur_y) - 33'(prev_y);
			px_s1 <= 33'(prev_x) - 33'(neighbor_prev_x);
			py_s1 <= 33'(prev_y) - 33'(neighbor_prev_y);
			dx_s1 <= dir_x;
			dy_s1 <= dir_y;
		end
	end

	// stage 2: cross and dot partial products
	always_ff @(posedge clk) begin
		if (en[1]) begin
			vypx_s2 <= 66'(vy_s1) * 66'(px_s1);
			vxpy_s2 <= 66'(vx_s1) * 66'(py_s1);
			vxpx_s2 <= 66'(vx_s1) * 66'(px_s1);
			vypy_s2 <= 66'(vy_s1) * 66'(py_s1);
			px_s2   <= px_s1;
			py_s2   <= py_s1;
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
		end
	end

	// stage 3: normal and tangential terms
	assign t1w = 67'(vypx_s2) - 67'(vxpy_s2);
	assign t2w = 67'(vxpx_s2) + 67'(vypy_s2);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			t1_s3 <= sat_t(t1w);
			t2_s3 <= sat_t(t2w);
		end
	end

	// side band delay line, activity test on the exact tangential term
	always_ff @(posedge clk) begin
		if (en[2]) begin
			side_s[3] <= '{pos: !t2w[66] && (t2w != '0), px: px_s2, py: py_s2,
				dx: dx_s2, dy: dy_s2};
		end
		for (int k = 4; k < NStage; k++) begin
			if (en[k-1]) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// t1, t2 wait for the second multiply level
	always_ff @(posedge clk) begin
		if (en[3]) begin
			t1_s4 <= t1_s3;
			t2_s4 <= t2_s3;
		end
		if (en[4]) begin
			t1_s5 <= t1_s4;
			t2_s5 <= t2_s4;
		end
		if (en[5]) begin
			t1_s6 <= t1_s5;
			t2_s6 <= t2_s5;
		end
	end

	assign qpx3 = widen_p(side_s[3].px);
	assign qpy3 = widen_p(side_s[3].py);

	// level 1: squares
	effk_qmul u_s1  (.clk, .en_a(en[3]), .en_b(en[4]), .a(t1_s3), .b(t1_s3), .p(s1_s5));
	effk_qmul u_s2  (.clk, .en_a(en[3]), .en_b(en[4]), .a(t2_s3), .b(t2_s3), .p(s2_s5));
	effk_qmul u_pxx (.clk, .en_a(en[3]), .en_b(en[4]), .a(qpx3), .b(qpx3), .p(pxx_s5));
	effk_qmul u_pyy (.clk, .en_a(en[3]), .en_b(en[4]), .a(qpy3), .b(qpy3), .p(pyy_s5));
	effk_qmul u_pxy (.clk, .en_a(en[3]), .en_b(en[4]), .a(qpx3), .b(qpy3), .p(pxy_s5));

	// stage 6: difference of squares
	always_ff @(posedge clk) begin
		if (en[5]) begin
			d21_s6 <= sat_sub(s2_s5, s1_s5);
			s1_s6  <= s1_s5;
			s2_s6  <= s2_s5;
			pxx_s6 <= pxx_s5;
			pyy_s6 <= pyy_s5;
			pxy_s6 <= pxy_s5;
		end
	end

	// level 2: cubes, fourth powers and Hessian products
	effk_qmul u_c1  (.clk, .en_a(en[6]), .en_b(en[7]), .a(s1_s6), .b(t1_s6), .p(c1_s8));
	effk_qmul u_c2  (.clk, .en_a(en[6]), .en_b(en[7]), .a(s2_s6), .b(t2_s6), .p(c2_s8));
	effk_qmul u_e1  (.clk, .en_a(en[6]), .en_b(en[7]), .a(s1_s6), .b(s1_s6), .p(e1_s8));
	effk_qmul u_e2  (.clk, .en_a(en[6]), .en_b(en[7]), .a(s2_s6), .b(s2_s6), .p(e2_s8));
	effk_qmul u_h1  (.clk, .en_a(en[6]), .en_b(en[7]), .a(pyy_s6), .b(s1_s6), .p(h1_s8));
	effk_qmul u_h2  (.clk, .en_a(en[6]), .en_b(en[7]), .a(pxx_s6), .b(s2_s6), .p(h2_s8));
	effk_qmul u_h3  (.clk, .en_a(en[6]), .en_b(en[7]), .a(pxx_s6), .b(s1_s6), .p(h3_s8));
	effk_qmul u_h4  (.clk, .en_a(en[6]), .en_b(en[7]), .a(pyy_s6), .b(s2_s6), .p(h4_s8));
	effk_qmul u_hxy (.clk, .en_a(en[6]), .en_b(en[7]), .a(pxy_s6), .b(d21_s6), .p(hxy_s8));

	// stage 9: energy sum and Hessian diagonal
	always_ff @(posedge clk) begin
		if (en[8]) begin
			esum_s9 <= sat_add(e1_s8, e2_s8);
			hxx_s9  <= sat_add(h1_s8, h2_s8);
			hyy_s9  <= sat_add(h3_s8, h4_s8);
			c1_s9   <= c1_s8;
			c2_s9   <= c2_s8;
			hxy_s9  <= hxy_s8;
		end
	end

	assign qpx9 = widen_p(side_s[9].px);
	assign qpy9 = widen_p(side_s[9].py);
	assign dx9  = widen_d(side_s[9].dx);
	assign dy9  = widen_d(side_s[9].dy);

	// level 3: gradient and direction products, scaled energy
	effk_qmul u_g1 (.clk, .en_a(en[9]), .en_b(en[10]), .a(qpx9), .b(c2_s9), .p(g1_s11));
	effk_qmul u_g2 (.clk, .en_a(en[9]), .en_b(en[10]), .a(qpy9), .b(c1_s9), .p(g2_s11));
	effk_qmul u_g3 (.clk, .en_a(en[9]), .en_b(en[10]), .a(qpx9), .b(c1_s9), .p(g3_s11));
	effk_qmul u_g4 (.clk, .en_a(en[9]), .en_b(en[10]), .a(qpy9), .b(c2_s9), .p(g4_s11));
	effk_qmul u_d1 (.clk, .en_a(en[9]), .en_b(en[10]), .a(dx9), .b(hxx_s9), .p(d1_s11));
	effk_qmul u_d2 (.clk, .en_a(en[9]), .en_b(en[10]), .a(dy9), .b(hxy_s9), .p(d2_s11));
	effk_qmul u_d3 (.clk, .en_a(en[9]), .en_b(en[10]), .a(dx9), .b(hxy_s9), .p(d3_s11));
	effk_qmul u_d4 (.clk, .en_a(en[9]), .en_b(en[10]), .a(dy9), .b(hyy_s9), .p(d4_s11));
	effk_qmul u_en (.clk, .en_a(en[9]), .en_b(en[10]), .a(esum_s9), .b(kf4),
		.p(energy_s11));

	// stage 12: gradient and direction sums
	always_ff @(posedge clk) begin
		if (en[11]) begin
			gx_s12     <= sat_sub(g1_s11, g2_s11);
			gy_s12     <= sat_add(g3_s11, g4_s11);
			dfx_s12    <= sat_add(d1_s11, d2_s11);
			dfy_s12    <= sat_add(d3_s11, d4_s11);
			energy_s12 <= energy_s11;
		end
	end

	// level 4: gain
	effk_qmul u_gx (.clk, .en_a(en[12]), .en_b(en[13]), .a(kf), .b(gx_s12), .p(grad_x_s14));
	effk_qmul u_gy (.clk, .en_a(en[12]), .en_b(en[13]), .a(kf), .b(gy_s12), .p(grad_y_s14));
	effk_qmul u_fx (.clk, .en_a(en[12]), .en_b(en[13]), .a(kf3), .b(dfx_s12), .p(diff_x_s14));
	effk_qmul u_fy (.clk, .en_a(en[12]), .en_b(en[13]), .a(kf3), .b(dfy_s12), .p(diff_y_s14));

	always_ff @(posedge clk) begin
		if (en[12]) begin
			energy_s13 <= energy_s12;
		end
		if (en[13]) begin
			energy_s14 <= energy_s13;
		end
	end

	// stage 15: output register, inactive edges give zeros
	always_ff @(posedge clk) begin
		if (en[14]) begin
			energy_s15 <= side_s[14].pos ? energy_s14 : '0;
			grad_x_s15 <= side_s[14].pos ? grad_x_s14 : '0;
			grad_y_s15 <= side_s[14].pos ? grad_y_s14 : '0;
			diff_x_s15 <= side_s[14].pos ? diff_x_s14 : '0;
			diff_y_s15 <= side_s[14].pos ? diff_y_s14 : '0;
			active_s15 <= side_s[14].pos && (friction_gain_q != '0);
		end
	end

	assign energy_term = energy_s15;
	assign grad_x      = grad_x_s15;
	assign grad_y      = grad_y_s15;
	assign diff_x      = diff_x_s15;
	assign diff_y      = diff_y_s15;
	assign active      = active_s15;

endmodule

[src/effk_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// effk_port_checker
// Port-level checks for the edge fluid friction kernel, bound to the top.
// ----------------------------------------------------------------------------
module effk_port_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [2:0]         paddr,
	input logic [31:0]        pwdata,
	input logic [31:0]        prdata,
	input logic               pready,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [63:0] energy_term,
	input logic signed [63:0] grad_x,
	input logic signed [63:0] grad_y,
	input logic signed [63:0] diff_x,
	input logic signed [63:0] diff_y,
	input logic               active
);

	// an inactive edge carries only zeros
	a_inactive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !active |-> energy_term == 64'sd0 && grad_x == 64'sd0 &&
		grad_y == 64'sd0 && diff_x == 64'sd0 && diff_y == 64'sd0)
		else $error("inactive edge with nonzero result");

	// energy is a sum of fourth powers times a nonnegative gain
	a_energy_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !energy_term[63])
		else $error("negative edge energy");

	// with no result waiting the input side never stalls
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output is empty");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(energy_term) &&
		$stable(grad_x) && $stable(diff_y) && $stable(active))
		else $error("stalled result changed");

	// the gain register reads back what was written
	a_gain_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[2] == 1'b0 |=>
		paddr[2] != 1'b0 || prdata == $past(pwdata))
		else $error("gain register readback mismatch");

endmodule

bind edge_fluid_friction_kernel effk_port_checker u_effk_checker (.*);

[bench/effk_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// effk_checker
// Watches the configuration port and both edge channels of the friction
// kernel. For every input transfer it works out the energy, gradient and
// Hessian-times-direction terms in saturating Q32.32 and queues them; every
// output transfer is compared field by field with the oldest queued entry.
// ----------------------------------------------------------------------------
module effk_checker import effk_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [CfgAddrW-1:0]   paddr,
	input  logic [31:0]           pwdata,
	input  logic [31:0]           prdata,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic signed [InW-1:0] cur_x,
	input  logic signed [InW-1:0] cur_y,
	input  logic signed [InW-1:0] prev_x,
	input  logic signed [InW-1:0] prev_y,
	input  logic signed [InW-1:0] neighbor_prev_x,
	input  logic signed [InW-1:0] neighbor_prev_y,
	input  logic signed [InW-1:0] dir_x,
	input  logic signed [InW-1:0] dir_y,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  q_t                    energy_term,
	input  q_t                    grad_x,
	input  q_t                    grad_y,
	input  q_t                    diff_x,
	input  q_t                    diff_y,
	input  logic                  active,
	output int                    fail_count,
	output int                    pending
);

	// exact intermediate wide enough for any product of two q32.32 values
	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		q_t   energy;
		q_t   gx;
		q_t   gy;
		q_t   dx;
		q_t   dy;
		logic act;
	} terms_t;

	localparam wide_t WideMax = QMax;
	localparam wide_t WideMin = QMin;
	localparam wide_t RoundHalf = 64'sh0000_0000_8000_0000;

	logic [31:0] gain;
	terms_t      expected_terms[$];
	terms_t      head;

	// clamp to the signed 64-bit range
	function automatic q_t clamp(input wide_t a);
		if (a > WideMax) return QMax;
		if (a < WideMin) return QMin;
		return q_t'(a);
	endfunction

	// q32.32 product, rounded half up, saturated
	function automatic q_t fx_mul(input q_t a, input q_t b);
		wide_t p;
		p = wide_t'(a) * wide_t'(b) + RoundHalf;
		return clamp(p >>> 32);
	endfunction

	function automatic q_t fx_add(input q_t a, input q_t b);
		return clamp(wide_t'(a) + wide_t'(b));
	endfunction

	function automatic q_t fx_sub(input q_t a, input q_t b);
		return clamp(wide_t'(a) - wide_t'(b));
	endfunction

	// friction terms of one edge under the given gain
	function automatic terms_t edge_terms(
		input logic signed [InW-1:0] cx, cy, px0, py0, nx, ny, ddx, ddy,
		input logic [31:0] kgain
	);
		wide_t       vx, vy, px, py, t1w, t2w;
		q_t          t1, t2, kf, kf4, kf3, qpx, qpy, dx, dy;
		q_t          s1, s2, c1, c2, pxx, pyy, pxy, hxx, hxy, hyy;
		logic [33:0] g3;
		terms_t      r;
		r = '0;
		vx = wide_t'(cx) - wide_t'(px0);
		vy = wide_t'(cy) - wide_t'(py0);
		px = wide_t'(px0) - wide_t'(nx);
		py = wide_t'(py0) - wide_t'(ny);
		t1w = vy * px - vx * py;
		t2w = vx * px + vy * py;
		// only a positive tangential term contributes
		if (t2w > 0) begin
			t1 = clamp(t1w);
			t2 = clamp(t2w);
			kf = {16'h0, kgain, 16'h0};
			kf4 = {18'h0, kgain, 14'h0};
			g3 = 34'(kgain) * 34'd3;
			kf3 = {14'h0, g3, 16'h0};
			qpx = q_t'(px <<< 16);
			qpy = q_t'(py <<< 16);
			dx = {{16{ddx[InW-1]}}, ddx, 16'h0};
			dy = {{16{ddy[InW-1]}}, ddy, 16'h0};
			s1 = fx_mul(t1, t1);
			s2 = fx_mul(t2, t2);
			c1 = fx_mul(s1, t1);
			c2 = fx_mul(s2, t2);
			pxx = fx_mul(qpx, qpx);
			pyy = fx_mul(qpy, qpy);
			pxy = fx_mul(qpx, qpy);
			hxx = fx_add(fx_mul(pyy, s1), fx_mul(pxx, s2));
			hxy = fx_mul(pxy, fx_sub(s2, s1));
			hyy = fx_add(fx_mul(pxx, s1), fx_mul(pyy, s2));
			r.energy = fx_mul(fx_add(fx_mul(s1, s1), fx_mul(s2, s2)), kf4);
			r.gx = fx_mul(kf, fx_sub(fx_mul(qpx, c2), fx_mul(qpy, c1)));
			r.gy = fx_mul(kf, fx_add(fx_mul(qpx, c1), fx_mul(qpy, c2)));
			r.dx = fx_mul(kf3, fx_add(fx_mul(dx, hxx), fx_mul(dy, hxy)));
			r.dy = fx_mul(kf3, fx_add(fx_mul(dx, hxy), fx_mul(dy, hyy)));
			r.act = (kgain != 0);
		end
		return r;
	endfunction

	task automatic check_field(input string name, input q_t want, input q_t got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			fail_count++;
		end
	endtask

	// register shadow, prediction on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain <= '0;
			expected_terms.delete();
			pending <= 0;
			fail_count = 0;
		end else begin
			if (psel && penable && pready && paddr[CfgAddrW-1:2] == RegFrictionGain) begin
				if (pwrite) begin
					gain <= pwdata;
				end else begin
					check_field("friction_gain", {32'h0, gain}, {32'h0, prdata});
				end
			end
			if (out_valid && !out_stall) begin
				if (expected_terms.size() == 0) begin
					$error("result transfer with nothing expected");
					fail_count++;
				end else begin
					head = expected_terms.pop_front();
					check_field("energy_term", head.energy, energy_term);
					check_field("grad_x", head.gx, grad_x);
					check_field("grad_y", head.gy, grad_y);
					check_field("diff_x", head.dx, diff_x);
					check_field("diff_y", head.dy, diff_y);
					check_field("active", {63'h0, head.act}, {63'h0, active});
				end
			end
			if (in_valid && !in_stall) begin
				expected_terms.push_back(edge_terms(cur_x, cur_y, prev_x, prev_y,
					neighbor_prev_x, neighbor_prev_y, dir_x, dir_y, gain));
			end
			pending <= expected_terms.size();
		end
	end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the edge fluid friction kernel: a directed set of edges at the
// value extremes and boundary cases, then random edges under a series of gain
// settings, with random input gaps and output stalls. The checker beside the
// block does the prediction and comparison and reports its failure count.
// ----------------------------------------------------------------------------
module testbench;
	import effk_pkg::*;

	localparam int unsigned IdleLimit    = 4000;
	localparam int unsigned TailCycles   = 20;
	localparam int unsigned ItemsPerGain = 130;

	localparam logic signed [InW-1:0] FxOne = 32'sh0001_0000;
	localparam logic signed [InW-1:0] FxTwo = 32'sh0002_0000;
	localparam logic signed [InW-1:0] FxMax = 32'sh7fff_ffff;
	localparam logic signed [InW-1:0] FxMin = 32'sh8000_0000;

	localparam logic [CfgAddrW-1:0] GainAddr  = {RegFrictionGain, 2'b00};
	localparam logic [CfgAddrW-1:0] SpareAddr = {~RegFrictionGain, 2'b00};

	typedef struct {
		logic signed [InW-1:0] cx, cy, px, py, nx, ny, dx, dy;
	} edge_in_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CfgAddrW-1:0]   paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic signed [InW-1:0] cur_x = '0;
	logic signed [InW-1:0] cur_y = '0;
	logic signed [InW-1:0] prev_x = '0;
	logic signed [InW-1:0] prev_y = '0;
	logic signed [InW-1:0] neighbor_prev_x = '0;
	logic signed [InW-1:0] neighbor_prev_y = '0;
	logic signed [InW-1:0] dir_x = '0;
	logic signed [InW-1:0] dir_y = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	q_t                    energy_term, grad_x, grad_y, diff_x, diff_y;
	logic                  active;
	int                    fail_count;
	int                    pending;
	int                    calm = 0;
	int                    stall_left = 0;
	int                    idle_cycles = 0;

	edge_fluid_friction_kernel u_dut (.*);

	effk_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// output stalls: mostly short bursts, now and then a long one
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (calm == 0 && $urandom_range(0, 99) < 30) begin
			out_stall <= 1'b1;
			stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50)
				: $urandom_range(0, 3);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("edge_fluid_friction_kernel: mismatch");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic edge_in_t make_edge(
		input logic signed [InW-1:0] cx, cy, px, py, nx, ny, dx, dy
	);
		edge_in_t e;
		e.cx = cx;
		e.cy = cy;
		e.px = px;
		e.py = py;
		e.nx = nx;
		e.ny = ny;
		e.dx = dx;
		e.dy = dy;
		return e;
	endfunction

	// mostly well-formed edges with small or moderate deltas, some raw noise
	function automatic edge_in_t random_edge();
		edge_in_t              e;
		logic signed [InW-1:0] bx, by, vx, vy, qx, qy;
		int                    pick, lo, sh;
		pick = $urandom_range(0, 99);
		e.dx = $signed($urandom) >>> $urandom_range(0, 31);
		e.dy = $signed($urandom) >>> $urandom_range(0, 31);
		if (pick < 15) begin
			e.cx = $urandom;
			e.cy = $urandom;
			e.px = $urandom;
			e.py = $urandom;
			e.nx = $urandom;
			e.ny = $urandom;
			return e;
		end
		lo = (pick < 70) ? 9 : 3;
		bx = $signed($urandom) >>> ((pick < 70) ? 1 : 3);
		by = $signed($urandom) >>> ((pick < 70) ? 1 : 3);
		qx = $signed($urandom) >>> $urandom_range(lo, 31);
		qy = $signed($urandom) >>> $urandom_range(lo, 31);
		// velocity along the edge keeps the tangential term positive
		if (pick >= 85) begin
			sh = $urandom_range(0, 4);
			vx = qx >>> sh;
			vy = qy >>> sh;
		end else begin
			vx = $signed($urandom) >>> $urandom_range(lo, 31);
			vy = $signed($urandom) >>> $urandom_range(lo, 31);
		end
		e.px = bx;
		e.py = by;
		e.cx = bx + vx;
		e.cy = by + vy;
		e.nx = bx - qx;
		e.ny = by - qy;
		return e;
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm != 0) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// one edge transfer, valid held until accepted
	task automatic send_edge(input edge_in_t e);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cur_x <= e.cx;
		cur_y <= e.cy;
		prev_x <= e.px;
		prev_y <= e.py;
		neighbor_prev_x <= e.nx;
		neighbor_prev_y <= e.ny;
		dir_x <= e.dx;
		dir_y <= e.dy;
		do @(posedge clk); while (in_stall);
	endtask

	// setup and access cycle on the register port
	task automatic cfg_access(input logic wr, input logic [CfgAddrW-1:0] addr,
		input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// wait until every expected result has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (2) @(posedge clk);
	endtask

	initial begin
		logic [31:0] gains [7];
		int unsigned k, n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		cfg_access(1'b0, GainAddr, '0);

		// zero gain straight after reset
		send_edge(make_edge(0, 0, 0, 0, 0, 0, 0, 0));
		send_edge(make_edge(FxOne, 0, 0, 0, -FxOne, 0, FxOne, FxOne));
		send_edge(make_edge(FxMax, FxMax, 0, 0, FxMin, FxMin, FxMax, FxMin));
		drain();

		// unit gain, directed edges
		cfg_access(1'b1, GainAddr, FxOne);
		cfg_access(1'b0, GainAddr, '0);
		send_edge(make_edge(0, 0, 0, 0, 0, 0, 0, 0));
		send_edge(make_edge(FxOne, 0, 0, 0, -FxOne, 0, FxOne, FxOne));
		// moving against the edge
		send_edge(make_edge(FxOne, 0, 0, 0, FxOne, 0, FxOne, FxOne));
		// velocity normal to the edge: tangential term exactly zero
		send_edge(make_edge(0, FxOne, 0, 0, -FxOne, 0, FxOne, -FxOne));
		send_edge(make_edge(FxOne, FxOne, 0, 0, -FxOne, 0, -FxOne, FxTwo));
		// smallest positive tangential term
		send_edge(make_edge(1, 0, 0, 0, -1, 0, FxMax, FxMin));
		// saturating edges at the field extremes
		send_edge(make_edge(FxMax, FxMax, 0, 0, FxMin, FxMin, FxMax, FxMin));
		send_edge(make_edge(FxMin, FxMin, 0, 0, FxMax, FxMax, FxMin, FxMax));
		send_edge(make_edge(FxMax, FxMin, FxMin, FxMax, FxMax, FxMin, 0, 0));
		// huge normal term over a tiny tangential one
		send_edge(make_edge(FxMax, 1, 0, 0, -1, 32'sh7fff_fffe, FxOne, FxOne));
		send_edge(make_edge(32'sh0000_8000, -32'sh0000_4000, 0, 0,
			-32'sh0003_0000, FxOne, -1, 1));
		// negative normal term
		send_edge(make_edge(FxOne, -FxOne, 0, 0, -FxTwo, -FxOne, -FxOne, -FxOne));
		drain();

		// random edges under a series of gains
		gains = '{32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, $urandom,
			$urandom >> $urandom_range(8, 24), 32'h0003_8000, $urandom};
		for (k = 0; k < 7; k++) begin
			cfg_access(1'b1, GainAddr, gains[k]);
			// a write beyond the last register must leave the gain alone
			if (k == 3) cfg_access(1'b1, SpareAddr, $urandom);
			cfg_access(1'b0, GainAddr, '0);
			for (n = 0; n < ItemsPerGain; n++) begin
				if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
				send_edge(random_edge());
			end
			drain();
			calm = 0;
		end

		repeat (TailCycles) @(posedge clk);
		if (fail_count == 0) begin
			$display("edge_fluid_friction_kernel: match");
		end else begin
			$display("edge_fluid_friction_kernel: mismatch");
		end
		$finish;
	end

endmodule

[edge_fluid_friction_kernel.f]
src/effk_pkg.sv
src/effk_qmul.sv
src/edge_fluid_friction_kernel.sv
src/effk_checker.sv
bench/effk_checker.sv
bench/testbench.sv
